// ----- sv/assert_macros.svh -----
// Assertion macros used by the RLE5 sprite decoder core.
// No dependencies; SYNTHESIS empties every macro body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define RLE5_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rle5 assertion failed");
// Condition must never be seen at a clock edge out of reset.
`define RLE5_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("rle5 forbidden condition seen");
`else
`define RLE5_ASSERT(label, clk, rst_n, prop)
`define RLE5_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- sv/rle5_pkg.sv -----
// Types, codes and constants of the RLE5 sprite decoder.
// No dependencies; used by every RTL module of the block.
package rle5_pkg;

	localparam int MAX_PIXELS_DEF = 1048576;
	localparam int SIZE_BITS_DEF  = 24;

	localparam int CSIZE_W   = 24;   // compressed_size register
	localparam int LIMIT_W   = 21;   // pixel_limit register
	localparam int CFG_W     = 24;   // widest register
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COMPRESSED_SIZE = 1'b0,
		CFG_PIXEL_LIMIT     = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_RUN   = 4'b0001,
		PH_FLAG  = 4'b0010,
		PH_COLOR = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	localparam logic [7:0] DATA_COUNT_MASK = 8'h7F;
	localparam logic [7:0] COLOR_FLAG      = 8'h80;
	localparam logic [7:0] COLOR_MASK      = 8'h1F;
	localparam int         REP_SHIFT       = 5;
	localparam logic [19:0] FIRST_PIXEL_MAX = 20'hFFFFF;

	typedef struct packed {
		logic       cmd;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  pixel_value;
		logic [8:0]  run_count;
		logic [19:0] first_pixel;
		logic        stream_done;
	} out_item_t;

endpackage

// ----- sv/rle5_cfg.sv -----
// Configuration registers of the RLE5 sprite decoder; pixel limit stored clamped.
// Depends on rle5_pkg.
module rle5_cfg #(
	parameter int MAX_PIXELS = rle5_pkg::MAX_PIXELS_DEF,
	localparam int PW = $clog2(MAX_PIXELS + 1),
	localparam int LW = (PW > rle5_pkg::LIMIT_W) ? PW : rle5_pkg::LIMIT_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rle5_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rle5_pkg::CFG_W-1:0]     cfg_data,
	output logic [rle5_pkg::CSIZE_W-1:0]   csize,
	output logic [LW-1:0]                  limit
);

	logic [rle5_pkg::CSIZE_W-1:0] csize_q;
	logic [LW-1:0]                limit_q;
	logic [LW-1:0]                lim_in;
	logic [LW-1:0]                lim_max;

	assign lim_in  = LW'(cfg_data[rle5_pkg::LIMIT_W-1:0]);
	assign lim_max = LW'(MAX_PIXELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csize_q <= '0;
			limit_q <= '0;
		end else if (cfg_we) begin
			case (rle5_pkg::cfg_idx_t'(cfg_index))
				rle5_pkg::CFG_COMPRESSED_SIZE: csize_q <= cfg_data[rle5_pkg::CSIZE_W-1:0];
				rle5_pkg::CFG_PIXEL_LIMIT:     limit_q <= (lim_in > lim_max) ? lim_max : lim_in;
				default: ;
			endcase
		end
	end

	assign csize = csize_q;
	assign limit = limit_q;

endmodule

// ----- sv/rle5_core.sv -----
// Decode core: input register, packet phase machine and counters, result register.
// Depends on rle5_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rle5_core #(
	parameter int MAX_PIXELS = rle5_pkg::MAX_PIXELS_DEF,
	parameter int SIZE_BITS  = rle5_pkg::SIZE_BITS_DEF,
	localparam int PW = $clog2(MAX_PIXELS + 1),
	localparam int LW = (PW > rle5_pkg::LIMIT_W) ? PW : rle5_pkg::LIMIT_W,
	localparam int CW = (SIZE_BITS > rle5_pkg::CSIZE_W) ? SIZE_BITS : rle5_pkg::CSIZE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rle5_pkg::CSIZE_W-1:0] csize,
	input  logic [LW-1:0]                limit,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  rle5_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rle5_pkg::out_item_t         out_data
);

	// input register
	logic               valid_s1;
	rle5_pkg::in_item_t item_s1;
	logic               adv;

	// decode state
	rle5_pkg::phase_t   phase_q;
	logic [7:0]         header_run_q;
	logic [6:0]         left_q;
	logic [SIZE_BITS-1:0] bc_q;
	logic [PW-1:0]      pw_q;
	logic               finished_q;

	// result register
	logic                out_valid_q;
	rle5_pkg::out_item_t out_q;

	// next-state logic
	rle5_pkg::phase_t   phase_n;
	logic [6:0]         left_n;
	logic [SIZE_BITS-1:0] bc_inc;
	logic               at_end;
	logic               end_after;
	logic               do_work;
	logic               emit;
	logic               last;
	logic [7:0]         color;
	logic [8:0]         want;
	logic [7:0]         b;
	logic [LW-1:0]      pw_ext;
	logic [LW-1:0]      room;
	logic [8:0]         run;
	logic [19:0]        start;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	assign b       = item_s1.in_byte;
	assign at_end  = CW'(bc_q) >= CW'(csize);
	assign bc_inc  = (bc_q == '1) ? bc_q : bc_q + 1'b1;
	assign end_after = CW'(bc_inc) >= CW'(csize);
	assign do_work = item_s1.cmd && !finished_q && !(phase_q == rle5_pkg::PH_RUN && at_end);

	always_comb begin
		phase_n = phase_q;
		left_n  = left_q;
		emit    = 1'b0;
		last    = 1'b0;
		color   = '0;
		want    = '0;
		case (phase_q)
			rle5_pkg::PH_RUN: begin
				phase_n = rle5_pkg::PH_FLAG;
			end
			rle5_pkg::PH_FLAG: begin
				left_n = b[6:0] & rle5_pkg::DATA_COUNT_MASK[6:0];
				if ((b & rle5_pkg::COLOR_FLAG) != '0) begin
					phase_n = rle5_pkg::PH_COLOR;
				end else begin
					emit    = 1'b1;
					last    = (left_n == '0);
					want    = {1'b0, header_run_q} + 9'd1;
					phase_n = last ? rle5_pkg::PH_RUN : rle5_pkg::PH_DATA;
				end
			end
			rle5_pkg::PH_COLOR: begin
				emit    = 1'b1;
				last    = (left_q == '0);
				color   = b;
				want    = {1'b0, header_run_q} + 9'd1;
				phase_n = last ? rle5_pkg::PH_RUN : rle5_pkg::PH_DATA;
			end
			rle5_pkg::PH_DATA: begin
				left_n  = left_q - 7'd1;
				emit    = 1'b1;
				last    = (left_n == '0);
				color   = b & rle5_pkg::COLOR_MASK;
				want    = 9'(b >> rle5_pkg::REP_SHIFT) + 9'd1;
				phase_n = last ? rle5_pkg::PH_RUN : rle5_pkg::PH_DATA;
			end
			default: begin
				phase_n = rle5_pkg::PH_RUN;
			end
		endcase
	end

	// clamp to the remaining budget
	assign pw_ext = LW'(pw_q);
	assign room   = (limit > pw_ext) ? (limit - pw_ext) : '0;
	assign run    = (LW'(want) < room) ? want : room[8:0];
	assign start  = (pw_ext > LW'(rle5_pkg::FIRST_PIXEL_MAX)) ?
		rle5_pkg::FIRST_PIXEL_MAX : pw_ext[19:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= rle5_pkg::PH_RUN;
			header_run_q <= '0;
			left_q       <= '0;
			bc_q         <= '0;
			pw_q         <= '0;
			finished_q   <= 1'b0;
		end else if (adv) begin
			if (!item_s1.cmd) begin
				phase_q      <= rle5_pkg::PH_RUN;
				header_run_q <= '0;
				left_q       <= '0;
				bc_q         <= '0;
				pw_q         <= '0;
				finished_q   <= 1'b0;
			end else if (!finished_q) begin
				if (phase_q == rle5_pkg::PH_RUN && at_end) begin
					finished_q <= 1'b1;
				end else begin
					bc_q    <= bc_inc;
					phase_q <= phase_n;
					left_q  <= left_n;
					if (phase_q == rle5_pkg::PH_RUN) begin
						header_run_q <= b;
					end
					if (emit) begin
						pw_q <= PW'(pw_ext + LW'(run));
						if (last) begin
							finished_q <= end_after;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= do_work && emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && do_work && emit) begin
			out_q.pixel_value <= color;
			out_q.run_count   <= run;
			out_q.first_pixel <= start;
			out_q.stream_done <= last && end_after;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`RLE5_ASSERT(a_data_has_count, clk, arst_n, (phase_q == rle5_pkg::PH_DATA) |-> (left_q != '0))
	`RLE5_ASSERT(a_finished_at_boundary, clk, arst_n, finished_q |-> (phase_q == rle5_pkg::PH_RUN))
	`RLE5_ASSERT(a_emit_loads_result, clk, arst_n, (adv && do_work && emit) |=> out_valid_q)
	`RLE5_ASSERT_NEVER(a_run_too_long, clk, arst_n, out_valid_q && (out_q.run_count > 9'd256))

endmodule

// ----- sv/rle5_sprite_decoder_top.sv -----
// Top level of the RLE5 sprite run-length decoder.
// Depends on rle5_pkg, rle5_cfg and rle5_core.
//
// The decoder takes one transaction per clock on the input channel while in_stall is low:
// cmd 0 starts a new sprite and clears the packet phase, byte count and pixel count; cmd 1
// delivers one compressed byte. A byte taken sits in the input register, where the decode
// logic works on it, and any run it produces is loaded into the result register when the
// byte advances, which waits while the run already there is stalled. The sustained rate is
// one byte per cycle while out_stall stays low.
// A byte that ends a packet header (flag without colour, or the colour byte) or any data
// byte yields one run transaction; run-length bytes and colour-announcing flag bytes yield
// none. Runs are clamped to the remaining pixel budget (pixel_limit, capped at MAX_PIXELS)
// and may be zero long. stream_done marks the run that closes the packet at or past
// compressed_size; after that, bytes are swallowed until the next cmd 0. The input register
// lets one byte be taken while a finished run still waits downstream; in_stall rises only
// while that byte is held and the run ahead of it is stalled. Configuration writes take
// effect at once and should only be made while the block is idle.
module rle5_sprite_decoder_top #(
	parameter int MAX_PIXELS = rle5_pkg::MAX_PIXELS_DEF,
	parameter int SIZE_BITS  = rle5_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [rle5_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rle5_pkg::CFG_W-1:0]     cfg_data,
	// compressed byte channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rle5_pkg::in_item_t            in_data,
	// run channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output rle5_pkg::out_item_t           out_data
);

	// limit width must cover both the register and the largest budget
	localparam int PW = $clog2(MAX_PIXELS + 1);
	localparam int LW = (PW > rle5_pkg::LIMIT_W) ? PW : rle5_pkg::LIMIT_W;

	logic [rle5_pkg::CSIZE_W-1:0] csize;
	logic [LW-1:0]                limit;

	rle5_cfg #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.csize    (csize),
		.limit    (limit)
	);

	// phase machine, counters and the run result register
	rle5_core #(
		.MAX_PIXELS(MAX_PIXELS),
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.csize    (csize),
		.limit    (limit),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
